/* src/ngv_pkg.sv */
// Package for the NGARCH variance recursion block.
// Holds register indexes, the sequencer state type and shared widths; no dependencies.
`default_nettype none
package ngv_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned CoefW = 16;
  localparam int unsigned NumCoefs = 4;

  localparam logic [2:0] REG_VAR_CONST   = 3'd0;
  localparam logic [2:0] REG_THETA       = 3'd1;
  localparam logic [2:0] REG_ARCH_ORDER  = 3'd2;
  localparam logic [2:0] REG_GARCH_ORDER = 3'd3;
  localparam logic [2:0] REG_ARCH_COEFS  = 3'd4;
  localparam logic [2:0] REG_GARCH_COEFS = 3'd5;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SQRT  = 7'b0000010,
    ST_THETA = 7'b0000100,
    ST_RESID = 7'b0001000,
    ST_ARCH  = 7'b0010000,
    ST_GARCH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // square-root unit control/status
  typedef struct packed {
    logic start;
  } sqrt_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_sts_t;
endpackage
`default_nettype wire

/* src/ngv_isqrt.sv */
// Bit-serial integer square root of a 48-bit radicand, one result bit per cycle.
// Uses ngv_pkg for its control and status structs.
`default_nettype none
module ngv_isqrt (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  ngv_pkg::sqrt_ctl_t     ctl,
  input  wire logic [47:0]       radicand,
  output ngv_pkg::sqrt_sts_t     sts,
  output logic      [23:0]       root
);
  logic [47:0] rem_r, rem_nxt;
  logic [23:0] res_r, res_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [25:0] part_r, part_nxt;
  logic [27:0] sub;

  // restoring method: bring down two radicand bits per step
  always_comb begin
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sub      = {1'b0, part_r[24:0], rem_r[47:46]} - {2'b00, res_r, 2'b01};
    if (ctl.start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      part_nxt = '0;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = {rem_r[45:0], 2'b00};
      cnt_nxt  = cnt_r + 5'd1;
      if (!sub[27]) begin
        part_nxt = sub[25:0];
        res_nxt  = {res_r[22:0], 1'b1};
      end else begin
        part_nxt = {part_r[23:0], rem_r[47:46]};
        res_nxt  = {res_r[22:0], 1'b0};
      end
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    part_r <= part_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = res_r;

`ifndef ASSERT_OFF
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> $past(busy_r)) else $error("sqrt done without busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("sqrt done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r) else $error("sqrt start not taken");
`endif
endmodule
`default_nettype wire

/* src/ngarch_variance_recursion.sv */
// Top level of the NGARCH(p,q) conditional variance filter, Q16.16.
// Depends on ngv_pkg and ngv_isqrt.
//
//  channel | ports                                 | direction
//  in      | in_valid, in_stall, in_sample         | sample in
//  out     | out_valid, out_stall, out_next_variance, out_saturated | variance out
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready   | registers
//
// Each sample runs through the square root, the theta product and residual, ARCH (three
// phases per lag in use), GARCH (one product per lag in use) and the result load; the
// next sample is taken only after the result has been loaded.
// The single 33x33 signed multiplier is shared by theta and all lag products.
// Reset (synchronous, rst_n low) clears configuration registers, state, histories and lag count.
// in_stall is high from acceptance until the result is loaded into the output
// register; the load waits while an earlier result is still stalled there.
`default_nettype none
module ngarch_variance_recursion #(
  parameter int unsigned MAX_ARCH_LAGS  = 4,
  parameter int unsigned MAX_GARCH_LAGS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_sample,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_next_variance,
  output logic             out_saturated,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  localparam int unsigned LagCap = (MAX_ARCH_LAGS > MAX_GARCH_LAGS) ?
                                   MAX_ARCH_LAGS : MAX_GARCH_LAGS;
  localparam int unsigned SeenW  = $clog2(LagCap + 1);
  localparam int unsigned AIdxW  = (MAX_ARCH_LAGS > 1) ? $clog2(MAX_ARCH_LAGS) : 1;
  localparam int unsigned GIdxW  = (MAX_GARCH_LAGS > 1) ? $clog2(MAX_GARCH_LAGS) : 1;
  localparam int unsigned KW     = 5;

  // ARCH lag phases: square, low half of e^2 product, high half
  localparam logic [1:0] PhSquare = 2'd0;
  localparam logic [1:0] PhLow    = 2'd1;
  localparam logic [1:0] PhHigh   = 2'd2;

  // configuration
  logic [31:0] var_const_r, theta_r;
  logic [2:0]  arch_order_r, garch_order_r;
  logic [63:0] arch_coefs_r, garch_coefs_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_const_r   <= '0;
      theta_r       <= '0;
      arch_order_r  <= '0;
      garch_order_r <= '0;
      arch_coefs_r  <= '0;
      garch_coefs_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        ngv_pkg::REG_VAR_CONST:   var_const_r   <= pwdata[31:0];
        ngv_pkg::REG_THETA:       theta_r       <= pwdata[31:0];
        ngv_pkg::REG_ARCH_ORDER:  arch_order_r  <= pwdata[2:0];
        ngv_pkg::REG_GARCH_ORDER: garch_order_r <= pwdata[2:0];
        ngv_pkg::REG_ARCH_COEFS:  arch_coefs_r  <= pwdata;
        ngv_pkg::REG_GARCH_COEFS: garch_coefs_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      ngv_pkg::REG_VAR_CONST:   prdata = {32'd0, var_const_r};
      ngv_pkg::REG_THETA:       prdata = {32'd0, theta_r};
      ngv_pkg::REG_ARCH_ORDER:  prdata = {61'd0, arch_order_r};
      ngv_pkg::REG_GARCH_ORDER: prdata = {61'd0, garch_order_r};
      ngv_pkg::REG_ARCH_COEFS:  prdata = arch_coefs_r;
      ngv_pkg::REG_GARCH_COEFS: prdata = garch_coefs_r;
      default:                  prdata = '0;
    endcase
  end

  // state
  ngv_pkg::state_t state_r, state_nxt;
  logic [31:0] cur_var_r;
  logic [31:0] res_hist_r [MAX_ARCH_LAGS];
  logic [31:0] var_hist_r [MAX_GARCH_LAGS];
  logic [SeenW-1:0] seen_r;
  logic [31:0] y_r, h_r;
  logic [31:0] h_sel;
  logic [63:0] prod_r;
  logic [49:0] acc_r;
  logic        sat_r;
  logic [KW-1:0] k_r;
  logic [1:0]  ph_r;
  logic [SeenW-1:0] na, ng;
  logic [31:0] out_var_r;
  logic        out_sat_r, out_valid_r;
  logic        out_load;

  ngv_pkg::sqrt_ctl_t sq_ctl;
  ngv_pkg::sqrt_sts_t sq_sts;
  logic [23:0] sq_root;

  // first sample uses var_const, later ones the last emitted variance
  assign h_sel = (seen_r == '0) ? var_const_r : cur_var_r;

  ngv_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .ctl(sq_ctl),
    .radicand({h_sel, 16'd0}), .sts(sq_sts), .root(sq_root)
  );

  wire in_acc  = in_valid & ~in_stall;
  wire out_acc = out_valid_r & ~out_stall;
  assign in_stall  = (state_r != ngv_pkg::ST_IDLE);
  assign sq_ctl.start = in_acc;
  assign out_load  = (state_r == ngv_pkg::ST_DONE) & (~out_valid_r | out_acc);

  // lag counts clamped by order and by samples seen (seen counted after push)
  always_comb begin
    na = (32'(arch_order_r) > MAX_ARCH_LAGS) ? SeenW'(MAX_ARCH_LAGS) : SeenW'(arch_order_r);
    if (na > seen_r) na = seen_r;
    ng = (32'(garch_order_r) > MAX_GARCH_LAGS) ? SeenW'(MAX_GARCH_LAGS) :
                                                 SeenW'(garch_order_r);
    if (ng > seen_r) ng = seen_r;
  end

  // shared multiplier: operands chosen by state
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [31:0] e_mag;
  logic [31:0] e_sel;
  logic [15:0] coef;
  always_comb begin
    e_sel = res_hist_r[k_r[AIdxW-1:0]];
    e_mag = e_sel[31] ? (~e_sel + 32'd1) : e_sel;
    coef  = '0;
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ngv_pkg::ST_SQRT: begin
        mul_a = {theta_r[31], theta_r};
        mul_b = {9'd0, sq_root};
      end
      ngv_pkg::ST_ARCH: begin
        if (k_r < KW'(ngv_pkg::NumCoefs)) coef = arch_coefs_r[16*k_r[1:0] +: 16];
        if (ph_r == PhSquare) begin
          mul_a = {1'b0, e_mag};
          mul_b = {1'b0, e_mag};
        end else if (ph_r == PhLow) begin
          mul_a = {17'd0, coef};
          mul_b = {1'b0, prod_r[47:16]};
        end else begin
          // e^2 is up to 63 bits: upper part handled as a second product
          mul_a = {17'd0, coef};
          mul_b = {18'd0, prod_r[62:48]};
        end
      end
      ngv_pkg::ST_GARCH: begin
        if (k_r < KW'(ngv_pkg::NumCoefs)) coef = garch_coefs_r[16*k_r[1:0] +: 16];
        mul_a = {17'd0, coef};
        mul_b = {1'b0, var_hist_r[k_r[GIdxW-1:0]]};
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // residual: y - floor(theta*sqrt/2^16), clipped to signed 32
  logic signed [48:0] shifted;
  logic signed [49:0] r_full;
  logic [31:0] r_clip;
  logic        r_sat;
  always_comb begin
    shifted = $signed({prod_r[63], prod_r[63:16]});
    r_full  = $signed({{18{y_r[31]}}, y_r}) - $signed({shifted[48], shifted});
    r_sat   = 1'b0;
    r_clip  = r_full[31:0];
    if (r_full > 50'sh7FFFFFFF) begin
      r_clip = 32'h7FFFFFFF; r_sat = 1'b1;
    end else if (r_full < -50'sh80000000) begin
      r_clip = 32'h80000000; r_sat = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ngv_pkg::ST_IDLE:  if (in_acc) state_nxt = ngv_pkg::ST_SQRT;
      ngv_pkg::ST_SQRT:  if (sq_sts.done) state_nxt = ngv_pkg::ST_THETA;
      ngv_pkg::ST_THETA: state_nxt = ngv_pkg::ST_RESID;
      ngv_pkg::ST_RESID: state_nxt = ngv_pkg::ST_ARCH;
      ngv_pkg::ST_ARCH:
        if (k_r >= KW'(na) || (ph_r == PhHigh && (k_r + KW'(1)) >= KW'(na)))
          state_nxt = ngv_pkg::ST_GARCH;
      ngv_pkg::ST_GARCH: if ((k_r + KW'(1)) >= KW'(ng))
          state_nxt = ngv_pkg::ST_DONE;
      ngv_pkg::ST_DONE:  if (out_load) state_nxt = ngv_pkg::ST_IDLE;
      default: state_nxt = ngv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ngv_pkg::ST_IDLE;
      cur_var_r   <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      ph_r        <= PhSquare;
      for (int i = 0; i < MAX_ARCH_LAGS; i++) res_hist_r[i] <= '0;
      for (int i = 0; i < MAX_GARCH_LAGS; i++) var_hist_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load | (out_valid_r & ~out_acc);
      unique case (state_r)
        ngv_pkg::ST_IDLE: if (in_acc) begin
          y_r   <= in_sample;
          h_r   <= h_sel;
          sat_r <= 1'b0;
        end
        ngv_pkg::ST_SQRT: if (sq_sts.done) prod_r <= 64'(mul_p);
        ngv_pkg::ST_THETA: ;
        ngv_pkg::ST_RESID: begin
          for (int i = MAX_ARCH_LAGS - 1; i > 0; i--) res_hist_r[i] <= res_hist_r[i-1];
          res_hist_r[0] <= r_clip;
          for (int i = MAX_GARCH_LAGS - 1; i > 0; i--) var_hist_r[i] <= var_hist_r[i-1];
          var_hist_r[0] <= h_r;
          if (seen_r < SeenW'(LagCap)) seen_r <= seen_r + 1'b1;
          sat_r <= r_sat;
          acc_r <= {18'd0, var_const_r};
          k_r   <= '0;
          ph_r  <= PhSquare;
        end
        ngv_pkg::ST_ARCH: begin
          if (k_r < KW'(na)) begin
            if (ph_r == PhSquare) prod_r <= 64'(mul_p);
            else if (ph_r == PhLow) acc_r <= acc_r + {18'd0, mul_p[47:16]};
            else acc_r <= acc_r + {3'd0, mul_p[30:0], 16'd0};
          end
          if (state_nxt == ngv_pkg::ST_GARCH) begin
            k_r  <= '0;
            ph_r <= PhSquare;
          end else if (ph_r == PhHigh) begin
            k_r  <= k_r + KW'(1);
            ph_r <= PhSquare;
          end else begin
            ph_r <= ph_r + 2'd1;
          end
        end
        ngv_pkg::ST_GARCH: begin
          if (k_r < KW'(ng)) acc_r <= acc_r + {18'd0, mul_p[47:16]};
          k_r <= k_r + KW'(1);
        end
        ngv_pkg::ST_DONE: if (out_load) begin
          if (acc_r[49:32] != '0) begin
            out_var_r <= 32'hFFFFFFFF; out_sat_r <= 1'b1; cur_var_r <= 32'hFFFFFFFF;
          end else begin
            out_var_r <= acc_r[31:0]; out_sat_r <= sat_r; cur_var_r <= acc_r[31:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_variance = out_var_r;
  assign out_saturated     = out_sat_r;

  logic unused;
  assign unused = ^{sq_sts.busy, mul_p[65:64], paddr[2:0], prod_r[15:0]};

`ifndef ASSERT_OFF
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ngv_pkg::ST_IDLE) |-> in_stall) else $error("ready while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ngv_pkg::ST_DONE) |=> out_valid) else $error("no result after done");
  a_seen_cap: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= SeenW'(LagCap)) else $error("lag count overflow");
`endif
endmodule
`default_nettype wire
